>>> src/stwm_pkg.sv
// Shared types and constants of the sorted two-way merge with color tags.
package stwm_pkg;

    // Width of the merged values; the low bits of each head are used.
    localparam int VALUE_WIDTH = 64;

    // Width of the head and emitted value fields on the channels.
    localparam int FIELD_WIDTH = 64;

    // Source color bits: bit 0 marks stream A, bit 1 marks stream B.
    localparam logic [1:0] COLOR_A = 2'b01;
    localparam logic [1:0] COLOR_B = 2'b10;

    // Stream popped by an item.
    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_A    = 2'd1,
        SIDE_B    = 2'd2
    } t_side;

    typedef logic [VALUE_WIDTH-1:0] t_value;

endpackage

>>> src/stwm_if.sv
// Valid/ready channel interfaces for the merge input heads and merge results.
interface stwm_in_if;
    logic                              valid;
    logic                              ready;
    logic [stwm_pkg::FIELD_WIDTH-1:0]  head_a;
    logic                              a_present;
    logic [stwm_pkg::FIELD_WIDTH-1:0]  head_b;
    logic                              b_present;

    modport source (output valid, head_a, a_present, head_b, b_present, input ready);
    modport sink   (input valid, head_a, a_present, head_b, b_present, output ready);
endinterface

interface stwm_out_if;
    logic                              valid;
    logic                              ready;
    stwm_pkg::t_side                   pop_side;
    logic                              emit_valid;
    logic [stwm_pkg::FIELD_WIDTH-1:0]  emit_value;
    logic [1:0]                        emit_color;
    logic                              emit_last;

    modport source (output valid, pop_side, emit_valid, emit_value, emit_color, emit_last,
                    input ready);
    modport sink   (input valid, pop_side, emit_valid, emit_value, emit_color, emit_last,
                    output ready);
endinterface

>>> src/sorted_two_way_merge_color_tag_core.sv
// Sorted two-way merge with duplicate folding and source color tags.
//
// Usage: i_in carries one item per step: the current heads of the ascending
// streams A and B with their presence flags. The block takes the smaller
// present head (B on a tie) and reports the popped side in o_out.pop_side.
// Equal consecutive values fold into one pending pair whose color collects
// the sources (bit 0 for A, bit 1 for B). A new value emits the pending pair.
// An item with neither head present flushes the pending pair with emit_last.
// Every accepted item gives exactly one result item on o_out.
//
// The result of an accepted item is registered and shown on o_out from the
// next cycle. Throughput is one item per cycle while o_out takes each result,
// set by the single compare and pending-pair update between the pending
// register and the output register. i_in.ready is high whenever the output
// register is empty or is being taken in the same cycle, so a stalled
// receiver holds the result and stops intake after one item. Reset clears
// the pending pair and the output valid flag, so a fresh merge starts.
module sorted_two_way_merge_color_tag_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stwm_in_if.sink           i_in,
    stwm_out_if.source        o_out
);

    // Pending pair.
    stwm_pkg::t_value  r_pend_value;
    logic [1:0]        r_pend_color;
    logic              r_pend_valid;

    // Output register.
    logic              r_out_valid;
    stwm_pkg::t_side   r_out_side;
    logic              r_out_emit;
    stwm_pkg::t_value  r_out_value;
    logic [1:0]        r_out_color;
    logic              r_out_last;

    // Next values.
    stwm_pkg::t_value  n_pend_value;
    logic [1:0]        n_pend_color;
    logic              n_pend_valid;
    stwm_pkg::t_side   n_out_side;
    logic              n_out_emit;
    stwm_pkg::t_value  n_out_value;
    logic [1:0]        n_out_color;
    logic              n_out_last;

    stwm_pkg::t_value  head_a;
    stwm_pkg::t_value  head_b;
    stwm_pkg::t_value  taken_value;
    logic [1:0]        taken_color;
    logic              take_a;
    logic              any_present;
    logic              fold;
    logic              in_accept;

    // Intake runs whenever the result slot is free or being emptied.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    assign head_a = i_in.head_a[stwm_pkg::VALUE_WIDTH-1:0];
    assign head_b = i_in.head_b[stwm_pkg::VALUE_WIDTH-1:0];

    // Pick the smaller present head, B on a tie.
    assign any_present = i_in.a_present || i_in.b_present;
    assign take_a      = i_in.a_present && (!i_in.b_present || (head_a < head_b));
    assign taken_value = take_a ? head_a : head_b;
    assign taken_color = take_a ? stwm_pkg::COLOR_A : stwm_pkg::COLOR_B;
    assign fold        = r_pend_valid && (taken_value == r_pend_value);

    // Merge decision for one item.
    always_comb begin
        n_pend_value = r_pend_value;
        n_pend_color = r_pend_color;
        n_pend_valid = r_pend_valid;
        n_out_side   = stwm_pkg::SIDE_NONE;
        n_out_emit   = 1'b0;
        n_out_value  = '0;
        n_out_color  = 2'b00;
        n_out_last   = 1'b0;
        if (!any_present) begin
            // Both streams ended: flush whatever is pending.
            if (r_pend_valid) begin
                n_out_emit   = 1'b1;
                n_out_value  = r_pend_value;
                n_out_color  = r_pend_color;
                n_out_last   = 1'b1;
                n_pend_valid = 1'b0;
            end
        end else begin
            n_out_side = take_a ? stwm_pkg::SIDE_A : stwm_pkg::SIDE_B;
            if (fold) begin
                n_pend_color = r_pend_color | taken_color;
            end else begin
                n_out_emit   = r_pend_valid;
                n_out_value  = r_pend_valid ? r_pend_value : '0;
                n_out_color  = r_pend_valid ? r_pend_color : 2'b00;
                n_pend_value = taken_value;
                n_pend_color = taken_color;
                n_pend_valid = 1'b1;
            end
        end
    end

    // Pending pair and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_value <= '0;
            r_pend_color <= 2'b00;
            r_pend_valid <= 1'b0;
        end else if (in_accept) begin
            r_pend_value <= n_pend_value;
            r_pend_color <= n_pend_color;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_side  <= n_out_side;
            r_out_emit  <= n_out_emit;
            r_out_value <= n_out_value;
            r_out_color <= n_out_color;
            r_out_last  <= n_out_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pop_side   = r_out_side;
    assign o_out.emit_valid = r_out_emit;
    assign o_out.emit_value = stwm_pkg::FIELD_WIDTH'(r_out_value);
    assign o_out.emit_color = r_out_color;
    assign o_out.emit_last  = r_out_last;

    // A result without an emission carries zero fields.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_emit) |->
            (r_out_value == '0 && r_out_color == 2'b00 && !r_out_last))
        else $error("result without emission has nonzero fields");

    // A final pair pops nothing and is always an emission with a color.
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_side == stwm_pkg::SIDE_NONE && r_out_emit && r_out_color != 2'b00))
        else $error("final pair malformed");

    // Taking a head always leaves a pair pending.
    a_take_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && any_present) |=> r_pend_valid)
        else $error("pending pair lost after taking a head");

    // A flush item empties the pending pair.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !any_present) |=> !r_pend_valid)
        else $error("pending pair survived a flush");

    // A pending pair always carries at least one source color.
    a_pend_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_pend_color != 2'b00))
        else $error("pending pair without color");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the sorted two-way merge with duplicate folding and color tags.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = stwm_pkg::FIELD_WIDTH;

    typedef logic [WORD_BITS-1:0] t_word;

    // One merge result as it appears on the output channel.
    typedef struct packed {
        stwm_pkg::t_side        side;
        logic                   emit_valid;
        t_word                  value;
        logic [1:0]             color;
        logic                   emit_last;
    } t_merge_result;

    // One input item; typed rows carry their result, the others use the model below.
    typedef struct packed {
        t_word                  head_a;
        logic                   a_present;
        t_word                  head_b;
        logic                   b_present;
        logic                   typed;
        t_merge_result          want;
    } t_stim_row;

    localparam stwm_pkg::t_side POP_NONE = stwm_pkg::SIDE_NONE;
    localparam stwm_pkg::t_side POP_A    = stwm_pkg::SIDE_A;
    localparam stwm_pkg::t_side POP_B    = stwm_pkg::SIDE_B;
    localparam logic [1:0]      TAG_A    = stwm_pkg::COLOR_A;
    localparam logic [1:0]      TAG_B    = stwm_pkg::COLOR_B;

    localparam t_word                  ALL_ONES = {WORD_BITS{1'b1}};
    localparam t_word                  TOP_BIT  = 64'h8000_0000_0000_0000;
    localparam t_word                  BELOW_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam t_word                  ALT_HI   = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam t_word                  ALT_LO   = 64'h5555_5555_5555_5555;
    localparam logic [1:0]             NO_COLOR = 2'b00;
    localparam logic [1:0]             BOTH     = TAG_A | TAG_B;
    localparam t_merge_result          FROM_MODEL = '0;
    localparam int                     RANDOM_ITEMS = 630;
    localparam int                     IDLE_PERCENT = 13;

    // Directed sequence: empty flush, first value, ties, all-ones values, folding,
    // repeated flush, unsorted input and a single stream left over.
    localparam int DIRECTED_ROWS = 21;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{64'd0,     1'b0, 64'd0,     1'b0, 1'b1, '{POP_NONE, 1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{64'd0,     1'b1, ALL_ONES,  1'b0, 1'b1, '{POP_A,    1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{64'd0,     1'b1, 64'd0,     1'b1, 1'b1, '{POP_B,    1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{64'd5,     1'b1, ALL_ONES,  1'b1, 1'b1, '{POP_A,    1'b1, 64'd0,    BOTH,     1'b0}},
        '{ALT_LO,    1'b0, ALL_ONES,  1'b1, 1'b1, '{POP_B,    1'b1, 64'd5,    TAG_A,    1'b0}},
        '{ALL_ONES,  1'b1, 64'd0,     1'b0, 1'b1, '{POP_A,    1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{64'd0,     1'b0, 64'd0,     1'b0, 1'b1, '{POP_NONE, 1'b1, ALL_ONES, BOTH,     1'b1}},
        '{ALL_ONES,  1'b0, ALL_ONES,  1'b0, 1'b1, '{POP_NONE, 1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{ALL_ONES,  1'b1, ALL_ONES,  1'b1, 1'b1, '{POP_B,    1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{64'd3,     1'b1, 64'd0,     1'b0, 1'b1, '{POP_A,    1'b1, ALL_ONES, TAG_B,    1'b0}},
        '{64'd3,     1'b1, 64'd3,     1'b1, 1'b1, '{POP_B,    1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{64'd2,     1'b1, 64'd7,     1'b1, 1'b1, '{POP_A,    1'b1, 64'd3,    BOTH,     1'b0}},
        '{ALT_HI,    1'b0, 64'd2,     1'b1, 1'b1, '{POP_B,    1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{64'd0,     1'b0, 64'd2,     1'b1, 1'b1, '{POP_B,    1'b0, 64'd0,    NO_COLOR, 1'b0}},
        '{64'd0,     1'b0, 64'd0,     1'b0, 1'b1, '{POP_NONE, 1'b1, 64'd2,    BOTH,     1'b1}},
        '{TOP_BIT,   1'b1, BELOW_TOP, 1'b1, 1'b0, FROM_MODEL},
        '{BELOW_TOP, 1'b1, TOP_BIT,   1'b1, 1'b0, FROM_MODEL},
        '{ALT_HI,    1'b1, ALT_LO,    1'b1, 1'b0, FROM_MODEL},
        '{ALT_LO,    1'b1, ALT_LO,    1'b1, 1'b0, FROM_MODEL},
        '{ALT_HI,    1'b0, ALT_HI,    1'b1, 1'b0, FROM_MODEL},
        '{64'd0,     1'b0, 64'd0,     1'b0, 1'b0, FROM_MODEL}
    };

    logic clk;
    logic rst_n;

    stwm_in_if  in_ch();
    stwm_out_if out_ch();

    sorted_two_way_merge_color_tag_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Model state: the one pending (value, color) pair.
    stwm_pkg::t_value pend_value;
    logic [1:0]       pend_color;
    logic             pend_valid;

    t_stim_row     stim_rows[$];
    t_merge_result expected_results[$];
    t_stim_row     cur_row;
    t_merge_result predicted;
    int            next_row;
    int            items_accepted;
    int            results_checked;
    int            pairs_emitted;
    int            flushes_seen;
    int            both_tagged;
    int            error_count;
    logic          quiet_stretch;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    // Picks a stream start: anywhere, very small, or close to the all-ones end.
    function automatic t_word pick_start();
        case ($urandom_range(0, 3))
            0: return t_word'($urandom_range(0, 6));
            1: return ALL_ONES - t_word'($urandom_range(0, 12));
            default: return rand_word();
        endcase
    endfunction

    // Ascending step that repeats values often and saturates at all ones.
    function automatic t_word step_up(t_word v);
        t_word d;
        d = t_word'($urandom_range(0, 3));
        if (v > ALL_ONES - d) return ALL_ONES;
        return v + d;
    endfunction

    task automatic push_row(input t_word a, input logic pa,
                            input t_word b, input logic pb);
        stim_rows.push_back('{a, pa, b, pb, 1'b0, FROM_MODEL});
    endtask

    // A well-formed merge of two short sorted streams, popped the way the block pops,
    // usually closed by a flush (sometimes two, sometimes none).
    task automatic add_merge_run();
        t_word                  sa[$];
        t_word                  sb[$];
        t_word                  v;
        t_word                  ha;
        t_word                  hb;
        logic                   pa;
        logic                   pb;
        int                     na;
        int                     nb;
        int                     ia;
        int                     ib;
        int                     ending;
        na = $urandom_range(0, 10);
        nb = $urandom_range(0, 10);
        v = pick_start();
        for (int i = 0; i < na; i++) begin
            sa.push_back(v);
            v = step_up(v);
        end
        if ($urandom_range(0, 1) == 0) v = pick_start();
        else if (na > 0) v = sa[0];
        for (int i = 0; i < nb; i++) begin
            sb.push_back(v);
            v = step_up(v);
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            pa = ia < na;
            pb = ib < nb;
            ha = pa ? sa[ia] : rand_word();
            hb = pb ? sb[ib] : rand_word();
            push_row(ha, pa, hb, pb);
            if (pa && (!pb || ha < hb)) ia++;
            else ib++;
        end
        ending = $urandom_range(0, 99);
        if (ending < 90) push_row(rand_word(), 1'b0, rand_word(), 1'b0);
        if (ending < 15) push_row(rand_word(), 1'b0, rand_word(), 1'b0);
    endtask

    // Unordered noise with frequent small values so that folds still happen.
    task automatic add_noise_row();
        t_word a;
        t_word b;
        a = ($urandom_range(0, 1) == 0) ? t_word'($urandom_range(0, 5)) : rand_word();
        b = ($urandom_range(0, 1) == 0) ? t_word'($urandom_range(0, 5)) : rand_word();
        if ($urandom_range(0, 9) == 0) a = ALL_ONES;
        if ($urandom_range(0, 9) == 0) b = ALL_ONES;
        push_row(a, 1'($urandom_range(0, 1)), b, 1'($urandom_range(0, 1)));
    endtask

    // Predicts the result of one item and advances the pending pair.
    function automatic t_merge_result merge_step(t_stim_row row);
        t_merge_result    r;
        stwm_pkg::t_value va;
        stwm_pkg::t_value vb;
        stwm_pkg::t_value taken;
        logic [1:0]       tag;
        r = '0;
        r.side = POP_NONE;
        va = row.head_a[stwm_pkg::VALUE_WIDTH-1:0];
        vb = row.head_b[stwm_pkg::VALUE_WIDTH-1:0];
        if (!row.a_present && !row.b_present) begin
            // Flush: emit whatever is pending and mark it last.
            if (pend_valid) begin
                r.emit_valid = 1'b1;
                r.value      = t_word'(pend_value);
                r.color      = pend_color;
                r.emit_last  = 1'b1;
                pend_valid   = 1'b0;
            end
        end else begin
            // B wins ties; a lone present head is always taken.
            if (row.a_present && (!row.b_present || va < vb)) begin
                r.side = POP_A;
                taken  = va;
                tag    = TAG_A;
            end else begin
                r.side = POP_B;
                taken  = vb;
                tag    = TAG_B;
            end
            if (pend_valid && taken == pend_value) begin
                pend_color = pend_color | tag;
            end else begin
                if (pend_valid) begin
                    r.emit_valid = 1'b1;
                    r.value      = t_word'(pend_value);
                    r.color      = pend_color;
                end
                pend_value = taken;
                pend_color = tag;
                pend_valid = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input t_word want,
                               input t_word got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Per-edge work: check results, record accepted items, drive both channels.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            // Compare each accepted result with the oldest expectation.
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("Result item with no expectation waiting (value 0x%0h)",
                           out_ch.emit_value);
                    error_count++;
                end else begin
                    predicted = expected_results.pop_front();
                    check_field("pop_side", predicted.side, out_ch.pop_side);
                    check_field("emit_valid", predicted.emit_valid, out_ch.emit_valid);
                    check_field("emit_value", predicted.value, out_ch.emit_value);
                    check_field("emit_color", predicted.color, out_ch.emit_color);
                    check_field("emit_last", predicted.emit_last, out_ch.emit_last);
                    results_checked++;
                    if (predicted.emit_valid) pairs_emitted++;
                    if (predicted.emit_last) flushes_seen++;
                    if (predicted.emit_valid && predicted.color == BOTH) both_tagged++;
                end
            end

            // The model advances on every accepted item, typed rows included.
            if (in_ch.valid && in_ch.ready) begin
                predicted = merge_step(cur_row);
                expected_results.push_back(cur_row.typed ? cur_row.want : predicted);
                items_accepted++;
            end
            quiet_stretch <= items_accepted >= 250 && items_accepted < 400;

            // Present the next item unless this cycle idles.
            if (!in_ch.valid || in_ch.ready) begin
                if (next_row < stim_rows.size() &&
                    (quiet_stretch || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    cur_row = stim_rows[next_row];
                    next_row++;
                    in_ch.head_a    <= cur_row.head_a;
                    in_ch.a_present <= cur_row.a_present;
                    in_ch.head_b    <= cur_row.head_b;
                    in_ch.b_present <= cur_row.b_present;
                    in_ch.valid     <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end

            out_ch.ready <= quiet_stretch || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    // Stimulus build, reset and end of run.
    initial begin
        in_ch.valid      = 1'b0;
        in_ch.head_a     = '0;
        in_ch.a_present  = 1'b0;
        in_ch.head_b     = '0;
        in_ch.b_present  = 1'b0;
        out_ch.ready     = 1'b0;
        rst_n            = 1'b0;
        pend_value       = '0;
        pend_color       = '0;
        pend_valid       = 1'b0;
        next_row         = 0;
        items_accepted   = 0;
        results_checked  = 0;
        pairs_emitted    = 0;
        flushes_seen     = 0;
        both_tagged      = 0;
        error_count      = 0;
        quiet_stretch    = 1'b0;

        for (int i = 0; i < DIRECTED_ROWS; i++) stim_rows.push_back(DIRECTED[i]);
        // Mostly well-formed merges, with some unordered noise between them.
        while (stim_rows.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 75) begin
                add_merge_run();
            end else begin
                repeat ($urandom_range(1, 4)) add_noise_row();
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (items_accepted < stim_rows.size() || expected_results.size() != 0);
        repeat (4) @(posedge clk);

        $display("Merged %0d items into %0d checked results: %0d pairs emitted, %0d of them",
                 items_accepted, results_checked, pairs_emitted, both_tagged);
        $display("tagged by both streams, and %0d end-of-stream flushes.", flushes_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("** sorted_two_way_merge_color_tag_core: PASSED **");
        end else begin
            $display("** sorted_two_way_merge_color_tag_core: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #200000;
        $display("** sorted_two_way_merge_color_tag_core: FAILED **");
        $finish;
    end

endmodule
